// ----- rtl/ftcr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ftcr_pkg;

    localparam int MAX_CONTEXTS = 16;
    localparam int MAX_STATES   = 256;
    localparam int MAX_EDGES    = 512;

    localparam int CTX_W  = 16;
    localparam int ST_W   = 16;
    localparam int SKEY_W = CTX_W + ST_W;
    localparam int EKEY_W = CTX_W + 2 * ST_W;

    localparam int CTX_IW = (MAX_CONTEXTS > 1) ? $clog2(MAX_CONTEXTS) : 1;

    typedef enum logic [1:0] {
        OVF_NONE  = 2'd0,
        OVF_CTX   = 2'd1,
        OVF_STATE = 2'd2,
        OVF_EDGE  = 2'd3
    } t_ovf;

    typedef struct packed {
        logic [CTX_W-1:0] context_id;
        logic [ST_W-1:0]  state_id;
    } t_in;

    typedef struct packed {
        logic            had_previous;
        logic [ST_W-1:0] from_state;
        logic            new_context;
        logic            new_state;
        logic            new_transition;
        logic [1:0]      overflow_code;
    } t_out;

    // search beat that travels down a key chain
    typedef struct packed {
        logic              valid;
        logic [EKEY_W-1:0] key;
        logic              hit;
        logic              free_found;
    } t_srch;

    // commit beat: write the key into the first free cell
    typedef struct packed {
        logic              valid;
        logic [EKEY_W-1:0] key;
        logic              done;
    } t_wr;

endpackage
`default_nettype wire

// ----- rtl/fsm_transition_coverage_recorder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// fsm transition coverage recorder
// input channel i_valid/o_ready carries one event (context_id, state_id);
// output channel o_valid/i_ready returns one result beat per event.
// contexts sit in a small register table searched combinationally; the
// (context, state) and (context, from, to) sets are chains of key cells,
// each cell one register stage, so a search beat walks the chain.
// one event at a time: the result waits for the longer, edge chain (the
// state chain runs alongside), and the next event is taken only after
// the result beat has been accepted.
// a new key is written by a commit beat sent down the chain after the
// search; it lands in the lowest free cell, so results match the
// lowest-free-slot allocation. commit overlaps the result wait.
// reset (synchronous, active low) empties every table.
// while the receiver stalls, the result holds and no event is taken.
module fsm_transition_coverage_recorder_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire ftcr_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire logic           i_ready,
    output ftcr_pkg::t_out      o_data
);

    localparam int CW = ftcr_pkg::CTX_W;
    localparam int SW = ftcr_pkg::ST_W;
    localparam int EW = ftcr_pkg::EKEY_W;

    typedef enum logic [1:0] {S_IDLE, S_SRCH, S_OUT} t_state;

    t_state          r_state;
    ftcr_pkg::t_in   r_in;
    ftcr_pkg::t_out  r_out;
    logic            r_s_go;
    logic            r_e_go;
    logic            r_s_wr;
    logic            r_e_wr;
    logic [CW-1:0]   r_ctx_key  [ftcr_pkg::MAX_CONTEXTS];
    logic [SW-1:0]   r_prev     [ftcr_pkg::MAX_CONTEXTS];
    logic [ftcr_pkg::MAX_CONTEXTS-1:0] r_cused;
    logic [ftcr_pkg::MAX_CONTEXTS-1:0] r_pknown;
    logic            r_ctx_hit;
    logic            r_ctx_free;
    logic [ftcr_pkg::CTX_IW-1:0] r_ci;
    logic            r_had;
    logic [SW-1:0]   r_from;
    logic            r_s_done;
    logic            r_e_done;
    logic            r_s_hit;
    logic            r_s_free;
    logic            r_e_hit;
    logic            r_e_free;

    logic            ctx_hit;
    logic            ctx_free;
    logic [ftcr_pkg::CTX_IW-1:0] ci;
    logic            prev_hit;
    logic [SW-1:0]   prev_st;
    logic            launch;
    logic            commit;
    ftcr_pkg::t_srch s_in;
    ftcr_pkg::t_srch e_in;
    ftcr_pkg::t_wr   s_wr;
    ftcr_pkg::t_wr   e_wr;
    ftcr_pkg::t_srch s_out;
    ftcr_pkg::t_srch e_out;
    logic            n_s_hit;
    logic            n_s_free;
    logic            n_e_hit;
    logic            n_e_free;
    ftcr_pkg::t_ovf  ovf;

    // context lookup: hit index or lowest free slot
    always_comb begin
        ctx_hit  = 1'b0;
        ctx_free = 1'b0;
        ci       = '0;
        for (int i = ftcr_pkg::MAX_CONTEXTS - 1; i >= 0; i--) begin
            if (!r_cused[i]) begin
                if (!ctx_hit) begin
                    ci = ftcr_pkg::CTX_IW'(i);
                end
                ctx_free = 1'b1;
            end
        end
        for (int i = ftcr_pkg::MAX_CONTEXTS - 1; i >= 0; i--) begin
            if (r_cused[i] && r_ctx_key[i] == r_in.context_id) begin
                ctx_hit = 1'b1;
                ci      = ftcr_pkg::CTX_IW'(i);
            end
        end
    end

    // previous state of the incoming context, needed for the edge key
    always_comb begin
        prev_hit = 1'b0;
        prev_st  = '0;
        for (int i = 0; i < ftcr_pkg::MAX_CONTEXTS; i++) begin
            if (r_cused[i] && r_pknown[i] && r_ctx_key[i] == i_data.context_id) begin
                prev_hit = 1'b1;
                prev_st  = r_prev[i];
            end
        end
    end

    // launch beats into the chains
    always_comb begin
        s_in            = '0;
        s_in.valid      = r_s_go;
        s_in.key        = EW'({r_in.context_id, r_in.state_id});
        e_in            = '0;
        e_in.valid      = r_e_go;
        e_in.key        = {r_in.context_id, r_from, r_in.state_id};
        s_wr            = '0;
        s_wr.valid      = r_s_wr;
        s_wr.key        = s_in.key;
        e_wr            = '0;
        e_wr.valid      = r_e_wr;
        e_wr.key        = e_in.key;
    end

    ftcr_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s_srch(s_in),
        .i_s_wr  (s_wr),
        .o_s_srch(s_out),
        .i_e_srch(e_in),
        .i_e_wr  (e_wr),
        .o_e_srch(e_out)
    );

    // collect chain answers as they drain
    always_comb begin
        n_s_hit  = r_s_done ? r_s_hit  : s_out.hit;
        n_s_free = r_s_done ? r_s_free : s_out.free_found;
        n_e_hit  = r_e_done ? r_e_hit  : e_out.hit;
        n_e_free = r_e_done ? r_e_free : e_out.free_found;
    end

    // overflow priority: context, state, transition
    always_comb begin
        if (!r_ctx_hit && !r_ctx_free) begin
            ovf = ftcr_pkg::OVF_CTX;
        end else if (!n_s_hit && !n_s_free) begin
            ovf = ftcr_pkg::OVF_STATE;
        end else if (r_had && !n_e_hit && !n_e_free) begin
            ovf = ftcr_pkg::OVF_EDGE;
        end else begin
            ovf = ftcr_pkg::OVF_NONE;
        end
    end

    // event taken, and both chains answered
    assign launch = (r_state == S_IDLE) && i_valid;
    assign commit = (r_state == S_SRCH) && (r_s_done || s_out.valid)
                    && (r_e_done || e_out.valid);

    // sequencer and tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_s_go   <= 1'b0;
            r_e_go   <= 1'b0;
            r_s_wr   <= 1'b0;
            r_e_wr   <= 1'b0;
            r_cused  <= '0;
            r_pknown <= '0;
            r_s_done <= 1'b0;
            r_e_done <= 1'b0;
        end else begin
            // launch in the cycle after capture, commit beats after the answer
            r_s_go <= launch;
            r_e_go <= launch;
            r_s_wr <= commit && (ovf == ftcr_pkg::OVF_NONE) && !n_s_hit;
            r_e_wr <= commit && (ovf == ftcr_pkg::OVF_NONE) && r_had && !n_e_hit;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_in     <= i_data;
                        r_had    <= prev_hit;
                        r_from   <= prev_st;
                        r_state  <= S_SRCH;
                        r_s_done <= 1'b0;
                        r_e_done <= 1'b0;
                    end
                end
                S_SRCH: begin
                    // context lookup registered on the launch cycle
                    if (r_s_go) begin
                        r_ctx_hit  <= ctx_hit;
                        r_ctx_free <= ctx_free;
                        r_ci       <= ci;
                    end
                    if (s_out.valid) begin
                        r_s_done <= 1'b1;
                        r_s_hit  <= s_out.hit;
                        r_s_free <= s_out.free_found;
                    end
                    if (e_out.valid) begin
                        r_e_done <= 1'b1;
                        r_e_hit  <= e_out.hit;
                        r_e_free <= e_out.free_found;
                    end
                    if (commit) begin
                        r_out.had_previous   <= r_had;
                        r_out.from_state     <= r_from;
                        r_out.overflow_code  <= ovf;
                        r_out.new_context    <= (ovf == ftcr_pkg::OVF_NONE) && !r_ctx_hit;
                        r_out.new_state      <= (ovf == ftcr_pkg::OVF_NONE) && !n_s_hit;
                        r_out.new_transition <= (ovf == ftcr_pkg::OVF_NONE) && r_had
                                                && !n_e_hit;
                        if (ovf == ftcr_pkg::OVF_NONE) begin
                            r_cused[r_ci]   <= 1'b1;
                            r_pknown[r_ci]  <= 1'b1;
                            r_ctx_key[r_ci] <= r_in.context_id;
                            r_prev[r_ci]    <= r_in.state_id;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_data  = r_out;

`ifndef SYNTH
    // a result only after an event was taken
    a_out_after_srch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_SRCH)
        else $error("result without search");
    // no new flags when overflowing
    a_ovf_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.overflow_code != ftcr_pkg::OVF_NONE |->
            !o_data.new_context && !o_data.new_state && !o_data.new_transition)
        else $error("overflow with new flags");
    // a transition needs a previous state
    a_tr_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.new_transition |-> o_data.had_previous)
        else $error("transition without previous");
    // never accept and present at once
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("ready during result");
`endif

endmodule
`default_nettype wire

// ----- rtl/ftcr_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ftcr_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ftcr_pkg::t_srch i_srch,
    input  wire ftcr_pkg::t_wr   i_wr,
    output ftcr_pkg::t_srch      o_srch,
    output ftcr_pkg::t_wr        o_wr
);

    logic                        r_used;
    logic [ftcr_pkg::EKEY_W-1:0] r_key;
    ftcr_pkg::t_srch             r_srch;
    ftcr_pkg::t_wr               r_wr;
    ftcr_pkg::t_srch             n_srch;
    ftcr_pkg::t_wr               n_wr;
    logic                        take;

    // compare against this cell's key, note any free slot
    always_comb begin
        n_srch            = i_srch;
        n_srch.hit        = i_srch.hit | (r_used && r_key == i_srch.key);
        n_srch.free_found = i_srch.free_found | ~r_used;
    end

    // first free cell on the write beat claims the key
    assign take = i_wr.valid && !i_wr.done && !r_used;
    always_comb begin
        n_wr      = i_wr;
        n_wr.done = i_wr.done | take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= 1'b0;
            r_srch.valid <= 1'b0;
            r_wr.valid   <= 1'b0;
        end else begin
            if (take) begin
                r_used <= 1'b1;
            end
            r_srch.valid <= n_srch.valid;
            r_wr.valid   <= n_wr.valid;
        end
        if (take) begin
            r_key <= i_wr.key;
        end
        r_srch.key        <= n_srch.key;
        r_srch.hit        <= n_srch.hit;
        r_srch.free_found <= n_srch.free_found;
        r_wr.key          <= n_wr.key;
        r_wr.done         <= n_wr.done;
    end

    assign o_srch = r_srch;
    assign o_wr   = r_wr;

endmodule
`default_nettype wire

// ----- rtl/ftcr_chain.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ftcr_chain (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ftcr_pkg::t_srch i_s_srch,
    input  wire ftcr_pkg::t_wr   i_s_wr,
    output ftcr_pkg::t_srch      o_s_srch,
    input  wire ftcr_pkg::t_srch i_e_srch,
    input  wire ftcr_pkg::t_wr   i_e_wr,
    output ftcr_pkg::t_srch      o_e_srch
);

    ftcr_pkg::t_srch s_srch [ftcr_pkg::MAX_STATES+1];
    ftcr_pkg::t_wr   s_wr   [ftcr_pkg::MAX_STATES+1];
    ftcr_pkg::t_srch e_srch [ftcr_pkg::MAX_EDGES+1];
    ftcr_pkg::t_wr   e_wr   [ftcr_pkg::MAX_EDGES+1];

    assign s_srch[0] = i_s_srch;
    assign s_wr[0]   = i_s_wr;
    assign e_srch[0] = i_e_srch;
    assign e_wr[0]   = i_e_wr;

    // row of (context, state) key cells, one stage per cell
    for (genvar g = 0; g < ftcr_pkg::MAX_STATES; g++) begin : g_scell
        ftcr_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_srch (s_srch[g]),
            .i_wr   (s_wr[g]),
            .o_srch (s_srch[g+1]),
            .o_wr   (s_wr[g+1])
        );
    end

    // row of (context, from, to) key cells, one stage per cell
    for (genvar g = 0; g < ftcr_pkg::MAX_EDGES; g++) begin : g_ecell
        ftcr_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_srch (e_srch[g]),
            .i_wr   (e_wr[g]),
            .o_srch (e_srch[g+1]),
            .o_wr   (e_wr[g+1])
        );
    end

    assign o_s_srch = s_srch[ftcr_pkg::MAX_STATES];
    assign o_e_srch = e_srch[ftcr_pkg::MAX_EDGES];

endmodule
`default_nettype wire
